>>> hdl/dmr_pkg.sv
// Shared constants and types for the dual multiply-with-carry random source.
package dmr_pkg;

  localparam logic [1:0] OP_RAW    = 2'd0;
  localparam logic [1:0] OP_RANGED = 2'd1;
  localparam logic [1:0] OP_RESEED = 2'd2;

  localparam logic [31:0] RESET_FIRST  = 32'd521288629;
  localparam logic [31:0] RESET_SECOND = 32'd362436069;
  localparam logic [15:0] RESET_MULT_X = 16'd18030;
  localparam logic [15:0] RESET_MULT_Y = 16'd31059;

  localparam logic CFG_MULT_X = 1'b0;
  localparam logic CFG_MULT_Y = 1'b1;

  localparam int DIV_STEPS = 31;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

>>> hdl/dmr_rem_unit.sv
// Radix-2 restoring remainder unit, one dividend bit per cycle.
module dmr_rem_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [30:0]       dividend,
  input  logic [32:0]       span,
  output logic [30:0]       rem,
  output dmr_pkg::rem_stat_t stat
);
  import dmr_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [30:0]      rem_r;
  logic [30:0]      rem_nxt;
  logic [30:0]      div_r;
  logic [32:0]      span_r;
  logic [31:0]      trial;
  logic [31:0]      diff;

  always_comb begin
    trial = {rem_r, div_r[30]};
    diff  = trial - span_r[31:0];
    if ({1'b0, trial} >= span_r) begin
      rem_nxt = diff[30:0];
    end else begin
      rem_nxt = trial[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      div_r  <= dividend;
      span_r <= span;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      div_r <= {div_r[29:0], 1'b0};
    end
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/dual_mwc_random_ranged_core.sv
// Dual multiply-with-carry random source with raw, ranged and reseed requests.
// An inverted range skips the remainder unit; reseed and unused opcodes go straight to the output stage.
// Requests are handled one at a time; ranged draws run through the 31-step remainder unit.
// Both generator words share one 16x16 multiplier, used in ST_MULX and then in ST_MULY.
// Synchronous active-low reset loads the seed words and multipliers to their defaults.
// A finished result waits in the output register while the next request is taken.
module dual_mwc_random_ranged_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // range_low, range_high, seed_first, seed_second
  input  logic [1:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // raw_value, ranged_value
  output logic [0:0]   out_tuser,  // range_error
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import dmr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULX  = 3'd1;
  localparam logic [2:0] ST_MULY  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIX   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]  state_r;
  logic [15:0] mult_x_r;
  logic [15:0] mult_y_r;
  logic [31:0] gen_first_r;
  logic [31:0] gen_second_r;
  logic [1:0]  op_r;
  logic [31:0] lo_r;
  logic [31:0] hi_r;
  logic        neg_r;
  logic [31:0] raw_r;
  logic [31:0] ranged_r;
  logic        err_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_err_r;

  logic        in_acc;
  logic        mul_sel;
  logic [15:0] mul_a;
  logic [31:0] mul_w;
  logic [31:0] mul_res;
  logic [32:0] span_c;
  logic [30:0] dividend_c;
  logic        div_start;
  logic [30:0] rem;
  rem_stat_t   rem_stat;
  logic [31:0] rem_ext;
  logic [31:0] rem_signed;
  logic        out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign mul_sel = (state_r == ST_MULY);
  assign mul_a   = mul_sel ? mult_y_r : mult_x_r;
  assign mul_w   = mul_sel ? gen_second_r : gen_first_r;
  assign mul_res = mul_a * mul_w[15:0] + {16'd0, mul_w[31:16]};

  assign span_c     = {hi_r[31], hi_r} - {lo_r[31], lo_r} + 33'd1;
  assign dividend_c = neg_r ? 31'd1 : (raw_r[31:1] - 31'd1);
  assign div_start  = (state_r == ST_SETUP) && !($signed(hi_r) < $signed(lo_r));

  assign rem_ext    = {1'b0, rem};
  assign rem_signed = neg_r ? (32'd0 - rem_ext) : rem_ext;

  dmr_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend_c),
    .span     (span_c),
    .rem      (rem),
    .stat     (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_x_r <= RESET_MULT_X;
      mult_y_r <= RESET_MULT_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MULT_X: mult_x_r <= cfg_data;
        CFG_MULT_Y: mult_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gen_first_r  <= RESET_FIRST;
      gen_second_r <= RESET_SECOND;
      out_valid_r  <= 1'b0;
    end else begin
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == OP_RAW || in_tuser == OP_RANGED) begin
              state_r <= ST_MULX;
            end else begin
              state_r <= ST_FIN;
              if (in_tuser == OP_RESEED) begin
                if (in_tdata[95:64] != 32'd0) gen_first_r <= in_tdata[95:64];
                if (in_tdata[127:96] != 32'd0) gen_second_r <= in_tdata[127:96];
              end
            end
          end
        end
        ST_MULX: begin
          gen_first_r <= mul_res;
          state_r     <= ST_MULY;
        end
        ST_MULY: begin
          gen_second_r <= mul_res;
          state_r      <= (op_r == OP_RANGED) ? ST_SETUP : ST_FIN;
        end
        ST_SETUP: begin
          state_r <= div_start ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (rem_stat.done) state_r <= ST_FIX;
        end
        ST_FIX: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r     <= in_tuser;
          lo_r     <= in_tdata[31:0];
          hi_r     <= in_tdata[63:32];
          raw_r    <= 32'd0;
          ranged_r <= 32'd0;
          err_r    <= 1'b0;
        end
      end
      ST_MULY: begin
        raw_r <= {gen_first_r[15:0], mul_res[15:0]};
        neg_r <= (gen_first_r[15:0] == 16'd0) && (mul_res[15:1] == 15'd0);
      end
      ST_SETUP: begin
        if (!div_start) err_r <= 1'b1;
      end
      ST_FIX: begin
        ranged_r <= rem_signed + lo_r;
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_r <= {ranged_r, raw_r};
          out_err_r  <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

endmodule

>>> tb/sv/dual_mwc_random_ranged_core_tb.sv
// Self-checking testbench for the dual multiply-with-carry random source.
module dual_mwc_random_ranged_core_tb;
  import dmr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] raw;
    logic [31:0] ranged;
    logic        err;
  } draw_result_t;

  class mwc_scoreboard;
    logic [15:0]  mult_x;
    logic [15:0]  mult_y;
    logic [31:0]  gen_first;
    logic [31:0]  gen_second;
    draw_result_t expected_draws[$];
    int unsigned  failures;

    function new();
      mult_x     = RESET_MULT_X;
      mult_y     = RESET_MULT_Y;
      gen_first  = RESET_FIRST;
      gen_second = RESET_SECOND;
      failures   = 0;
    endfunction

    function void set_mult(logic idx, logic [15:0] value);
      if (idx == CFG_MULT_X) begin
        mult_x = value;
      end else begin
        mult_y = value;
      end
    endfunction

    function logic [31:0] mwc_advance(logic [31:0] word, logic [15:0] mult);
      logic [63:0] prod;
      prod = 64'(mult) * 64'(word[15:0]) + 64'(word[31:16]);
      return prod[31:0];
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] lo_bits, logic [31:0] hi_bits,
                               logic [31:0] seed_a, logic [31:0] seed_b);
      draw_result_t res;
      longint       lo;
      longint       hi;
      longint       span;
      longint       rem;
      logic [31:0]  shifted;
      logic [63:0]  mapped;
      res.raw    = '0;
      res.ranged = '0;
      res.err    = 1'b0;
      case (op)
        OP_RAW, OP_RANGED: begin
          gen_first  = mwc_advance(gen_first, mult_x);
          gen_second = mwc_advance(gen_second, mult_y);
          res.raw    = {gen_first[15:0], gen_second[15:0]};
          if (op == OP_RANGED) begin
            lo = $signed(lo_bits);
            hi = $signed(hi_bits);
            if (hi < lo) begin
              res.err = 1'b1;
            end else begin
              span       = hi - lo + 1;
              shifted    = (res.raw >> 1) - 32'd1;
              rem        = $signed(shifted) % span;
              mapped     = rem + lo;
              res.ranged = mapped[31:0];
            end
          end
        end
        OP_RESEED: begin
          if (seed_a != 32'd0) gen_first = seed_a;
          if (seed_b != 32'd0) gen_second = seed_b;
        end
        default: ;
      endcase
      expected_draws.push_back(res);
    endfunction

    function void check_result(logic [31:0] raw, logic [31:0] ranged, logic err);
      draw_result_t want;
      if (expected_draws.size() == 0) begin
        $error("unexpected result: raw_value %h ranged_value %h range_error %b",
               raw, ranged, err);
        failures++;
        return;
      end
      want = expected_draws.pop_front();
      if (raw !== want.raw) begin
        $error("raw_value: expected %h, actual %h", want.raw, raw);
        failures++;
      end
      if (ranged !== want.ranged) begin
        $error("ranged_value: expected %h, actual %h", want.ranged, ranged);
        failures++;
      end
      if (err !== want.err) begin
        $error("range_error: expected %b, actual %b", want.err, err);
        failures++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [15:0]  cfg_data;

  mwc_scoreboard draws;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;

  dual_mwc_random_ranged_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      draws.check_result(out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
    end
  end

  task automatic idle_gap();
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      while ($urandom_range(99) < gap_pct) @(negedge clk);
    end
  endtask

  task automatic send_request(logic [1:0] op, logic [31:0] lo, logic [31:0] hi,
                              logic [31:0] seed_a, logic [31:0] seed_b);
    idle_gap();
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {seed_b, seed_a, hi, lo};
    do @(posedge clk); while (!in_tready);
    draws.note_request(op, lo, hi, seed_a, seed_b);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] seed_a;
    logic [31:0] seed_b;
    pick   = $urandom_range(99);
    op     = (pick < 33) ? OP_RAW : (pick < 78) ? OP_RANGED : (pick < 95) ? OP_RESEED : OP_UNUSED;
    lo     = $urandom;
    hi     = $urandom;
    seed_a = $urandom;
    seed_b = $urandom;
    case ($urandom_range(4))
      1: hi = lo + $urandom_range(255);
      2: hi = lo;
      3: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      4: begin
        lo = 32'h8000_0000 + $urandom_range(15);
        hi = 32'h7fff_ffff - $urandom_range(15);
      end
      default: ;
    endcase
    if ($urandom_range(3) == 0) seed_a = '0;
    if ($urandom_range(3) == 0) seed_b = '0;
    send_request(op, lo, hi, seed_a, seed_b);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (draws.expected_draws.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_multipliers(logic [15:0] x, logic [15:0] y);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MULT_X;
    cfg_data  <= x;
    @(negedge clk);
    cfg_index <= CFG_MULT_Y;
    cfg_data  <= y;
    @(negedge clk);
    cfg_we <= 1'b0;
    draws.set_mult(CFG_MULT_X, x);
    draws.set_mult(CFG_MULT_Y, y);
  endtask

  task automatic run_phase(int count, int gap, int stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) send_random_request();
  endtask

  // A seed whose next word has a zero low half, so the draw returns zero.
  function automatic logic [31:0] zeroing_seed(logic [15:0] mult);
    logic [31:0] upper;
    upper = 32'h0001_0000 - 32'(mult);
    return {upper[15:0], 16'h0001};
  endfunction

  initial begin
    draws     = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_RAW;
    cfg_we    = 1'b0;
    cfg_index = CFG_MULT_X;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(OP_RAW, '0, '0, '0, '0);
    send_request(OP_RAW, '1, '1, '1, '1);
    send_request(OP_RANGED, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send_request(OP_RANGED, 32'h0000_0000, 32'h0000_0000, '0, '0);
    send_request(OP_RANGED, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0);
    send_request(OP_RANGED, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_request(OP_RANGED, 32'h0000_0000, 32'hffff_ffff, '0, '0);
    send_request(OP_RANGED, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_request(OP_RANGED, 32'hffff_fffb, 32'h0000_0005, '0, '0);
    send_request(OP_RANGED, 32'h0000_0000, 32'h0000_ffff, '0, '0);
    send_request(OP_RANGED, 32'h7fff_fff0, 32'h7fff_ffff, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1, '1);
    send_request(OP_RESEED, '0, '0, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_RAW, '0, '0, '0, '0);
    send_request(OP_RESEED, '1, '1, '0, '0);
    send_request(OP_RAW, '0, '0, '0, '0);
    send_request(OP_RESEED, '0, '0, '0, 32'h1234_5678);
    send_request(OP_RESEED, '0, '0, 32'hdead_beef, '0);
    send_request(OP_RANGED, 32'h8000_0000, 32'h8000_0005, '0, '0);
    send_request(OP_RESEED, '0, '0, zeroing_seed(RESET_MULT_X), zeroing_seed(RESET_MULT_Y));
    send_request(OP_RANGED, 32'hffff_fff6, 32'h0000_000a, '0, '0);
    send_request(OP_RAW, '0, '0, '0, '0);
    send_request(OP_UNUSED, '0, '0, '0, '0);
    wait_idle();

    set_multipliers(16'hffff, 16'h0000);
    run_phase(140, 56, 0);
    wait_idle();

    set_multipliers(16'h0000, 16'hffff);
    run_phase(140, 0, 56);
    wait_idle();

    set_multipliers(16'($urandom), 16'($urandom));
    run_phase(140, 6, 6);
    wait_idle();

    set_multipliers(16'($urandom), 16'($urandom));
    @(posedge clk);
    hold_cycles = 300;
    run_phase(20, 0, 0);
    run_phase(100, 0, 0);
    wait_idle();

    if (draws.failures == 0 && draws.expected_draws.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
